@@ hdl/btr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and glyph lookup for the bitmap text generator.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int GLYPH_COUNT        = 48;
  localparam int GAP_COLUMNS_DEF    = 1;
  localparam int QUEUE_DEPTH_DEF    = 2;
  localparam int CELLS              = 16;
  localparam int SCALE_MAX          = 16;

  // register indexes of the configuration port
  localparam logic [1:0] REG_PIXEL_SCALE  = 2'd0;
  localparam logic [1:0] REG_INK_COLOUR   = 2'd1;
  localparam logic [1:0] REG_PAPER_COLOUR = 2'd2;

  localparam logic [4:0]  PIXEL_SCALE_RST  = 5'd1;
  localparam logic [15:0] INK_COLOUR_RST   = 16'hFFFF;
  localparam logic [15:0] PAPER_COLOUR_RST = 16'h0000;

  // bit 15 is the top-left cell, row-major
  localparam logic [15:0] GLYPH_ROM [GLYPH_COUNT] = '{
    16'h7DFD, 16'hEBDF, 16'h7CCF, 16'hEDDE, 16'hFECF,
    16'hFECC, 16'h7CDF, 16'hDFFD, 16'hF66F, 16'hF3BF,
    16'hDEED, 16'hCCCF, 16'hFB99, 16'hDDBB, 16'h7DDF,
    16'hFDFC, 16'h6AAF, 16'hFDED, 16'hFC3F, 16'hF666,
    16'hDDD7, 16'h99B6, 16'h99BF, 16'hDE7B, 16'hDF66,
    16'hF3CF, 16'h7DDF, 16'hE66F, 16'hF3EF, 16'hF13F,
    16'hDDF1, 16'hFC7F, 16'h8F9F, 16'hF366, 16'h7DBE,
    16'hF9F1, 16'h0002, 16'h2200, 16'h5500, 16'hF302,
    16'h6606, 16'hC88C, 16'h3113, 16'h04E4, 16'h00E0,
    16'h2020, 16'h8226, 16'h0000
  };

  typedef struct packed {
    logic [7:0]  char_code;
    logic        start_of_string;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } char_word_t;

  typedef struct packed {
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [4:0]  rect_side;
    logic [15:0] fill_colour;
    logic        last_of_glyph;
  } rect_word_t;

  // one glyph waiting to be drawn
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] glyph;
  } glyph_job_t;

  typedef struct packed {
    logic [4:0]  side;
    logic [15:0] ink;
    logic [15:0] paper;
  } draw_cfg_t;

  // clamp scale into 1..16
  function automatic logic [4:0] eff_scale(input logic [4:0] scale);
    logic [4:0] s;
    if (scale == 5'd0) begin
      s = 5'd1;
    end else if (scale > 5'(SCALE_MAX)) begin
      s = 5'(SCALE_MAX);
    end else begin
      s = scale;
    end
    return s;
  endfunction

  // map a character code to its glyph; unknown codes draw as 'a'
  function automatic logic [15:0] glyph_lookup(input logic [7:0] code);
    logic [5:0] idx;
    idx = 6'd0;
    if (code >= 8'h61 && code <= 8'h7A) begin
      idx = 6'(code - 8'h61);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      idx = 6'(code - 8'h30 + 8'd26);
    end else begin
      case (code)
        8'h2E:   idx = 6'd36;
        8'h27:   idx = 6'd37;
        8'h22:   idx = 6'd38;
        8'h3F:   idx = 6'd39;
        8'h21:   idx = 6'd40;
        8'h5B:   idx = 6'd41;
        8'h5D:   idx = 6'd42;
        8'h2B:   idx = 6'd43;
        8'h2D:   idx = 6'd44;
        8'h3A:   idx = 6'd45;
        8'h3B:   idx = 6'd46;
        8'h20:   idx = 6'd47;
        default: idx = 6'd0;
      endcase
    end
    return GLYPH_ROM[idx];
  endfunction

endpackage
`default_nettype wire

@@ hdl/btr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btr_front
// Accepts character words, tracks the pen and queues non-blank glyphs.
// ----------------------------------------------------------------------------
module btr_front #(
  parameter int GAP_COLUMNS = btr_pkg::GAP_COLUMNS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    chr_valid,
  output logic                   chr_ready,
  input  btr_pkg::char_word_t    chr,
  input  wire [4:0]              side,
  input  wire                    q_full,
  output logic                   q_push,
  output btr_pkg::glyph_job_t    q_job
);
  import btr_pkg::*;

  localparam logic [15:0] ADVANCE = 16'(4 + GAP_COLUMNS);

  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] glyph;
  logic        accept;

  assign chr_ready = !q_full;
  assign accept    = chr_valid && chr_ready;

  always_comb begin
    start_x = chr.start_of_string ? chr.origin_x : pen_x;
    start_y = chr.start_of_string ? chr.origin_y : pen_y;
    glyph   = glyph_lookup(chr.char_code);
  end

  // blank glyphs move the pen but emit nothing
  assign q_push      = accept && (glyph != 16'd0);
  assign q_job.x     = start_x;
  assign q_job.y     = start_y;
  assign q_job.glyph = glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= 16'd0;
      pen_y <= 16'd0;
    end else if (accept) begin
      pen_x <= start_x + 16'(ADVANCE * {11'd0, side});
      pen_y <= start_y;
    end
  end

endmodule
`default_nettype wire

@@ hdl/btr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btr_queue
// Small FIFO of glyph jobs between front and back.
// ----------------------------------------------------------------------------
module btr_queue #(
  parameter int DEPTH = btr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  btr_pkg::glyph_job_t    push_job,
  input  wire                    pop,
  output logic                   full,
  output logic                   not_empty,
  output btr_pkg::glyph_job_t    head
);
  import btr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  glyph_job_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/btr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btr_back
// Expands one glyph job into sixteen squares, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module btr_back (
  input  wire                    clk,
  input  wire                    rst,
  input  btr_pkg::draw_cfg_t     cfg,
  input  wire                    q_not_empty,
  input  btr_pkg::glyph_job_t    q_head,
  output logic                   q_pop,
  output logic                   rect_valid,
  input  wire                    rect_ready,
  output btr_pkg::rect_word_t    rect
);
  import btr_pkg::*;

  logic        active;
  logic [3:0]  cell_idx;
  logic [15:0] glyph;
  logic [15:0] base_x;
  logic [15:0] col_x;
  logic [15:0] row_y;
  logic        can_emit;
  logic        emit;
  logic        last_cell;

  assign can_emit  = !rect_valid || rect_ready;
  assign emit      = can_emit && active;
  assign last_cell = (cell_idx == 4'(CELLS - 1));
  // load the next job when idle, or right behind the final square
  assign q_pop     = q_not_empty && (!active || (emit && last_cell));

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      rect_valid <= 1'b0;
      cell_idx   <= 4'd0;
    end else begin
      if (emit) begin
        rect_valid <= 1'b1;
        // wraps to zero after the final square
        cell_idx   <= cell_idx + 4'd1;
        if (last_cell) begin
          active <= q_pop;
        end
      end else begin
        if (rect_ready) begin
          rect_valid <= 1'b0;
        end
        if (q_pop) begin
          active   <= 1'b1;
          cell_idx <= 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rect.rect_x        <= col_x;
      rect.rect_y        <= row_y;
      rect.rect_side     <= cfg.side;
      rect.fill_colour   <= glyph[4'd15 - cell_idx] ? cfg.ink : cfg.paper;
      rect.last_of_glyph <= last_cell;
    end
    if (q_pop) begin
      glyph  <= q_head.glyph;
      base_x <= q_head.x;
      col_x  <= q_head.x;
      row_y  <= q_head.y;
    end else if (emit) begin
      // step right, or wrap to the start of the next row
      if (cell_idx[1:0] == 2'd3) begin
        col_x <= base_x;
        row_y <= row_y + {11'd0, cfg.side};
      end else begin
        col_x <= col_x + {11'd0, cfg.side};
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/bitmap_text_to_rect_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_to_rect_generator
// 4x4 bitmap font character generator emitting filled squares.
// ----------------------------------------------------------------------------
// Each accepted character word is looked up in a 48-glyph font and drawn as
// sixteen squares in row-major order, one square word per cycle while the
// output is ready, counted by the single cell counter of the drawing stage.
// A blank glyph moves the pen and emits nothing. The front end tracks the
// pen and runs up to QUEUE_DEPTH glyphs ahead of drawing. Configuration
// registers: 0 pixel scale (0 acts as 1, above 16 acts as 16), 1 ink colour,
// 2 paper colour; write them only while the block is idle.
module bitmap_text_to_rect_generator #(
  parameter int GAP_COLUMNS = btr_pkg::GAP_COLUMNS_DEF,
  parameter int QUEUE_DEPTH = btr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_index,
  input  wire [15:0]             cfg_data,
  input  wire                    chr_valid,
  output logic                   chr_ready,
  input  btr_pkg::char_word_t    chr,
  output logic                   rect_valid,
  input  wire                    rect_ready,
  output btr_pkg::rect_word_t    rect
);
  import btr_pkg::*;

  logic [4:0]  pixel_scale;
  logic [15:0] ink_colour;
  logic [15:0] paper_colour;
  draw_cfg_t   cfg;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  glyph_job_t  q_job;
  glyph_job_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale  <= PIXEL_SCALE_RST;
      ink_colour   <= INK_COLOUR_RST;
      paper_colour <= PAPER_COLOUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_SCALE:  pixel_scale  <= cfg_data[4:0];
        REG_INK_COLOUR:   ink_colour   <= cfg_data;
        REG_PAPER_COLOUR: paper_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.side  = eff_scale(pixel_scale);
  assign cfg.ink   = ink_colour;
  assign cfg.paper = paper_colour;

  btr_front #(
    .GAP_COLUMNS (GAP_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr),
    .side      (cfg.side),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  btr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  btr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .rect_valid  (rect_valid),
    .rect_ready  (rect_ready),
    .rect        (rect)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Bitmap text generator testbench
// Drives character words through the valid/ready input, predicts the sixteen
// squares of each glyph from a local font table and pen tracker, and checks
// every square word at the output under several scale and colour settings
// and with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
package glyph_bench_pkg;
  import btr_pkg::*;

  // the register port has four indexes; the last one selects nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [7:0] FONT_CODES [48] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
    "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    ".", "'", "\"", "?", "!", "[", "]", "+", "-", ":", ";", " "
  };

  localparam logic [15:0] FONT_BITS [48] = '{
    16'h7DFD, 16'hEBDF, 16'h7CCF, 16'hEDDE, 16'hFECF,
    16'hFECC, 16'h7CDF, 16'hDFFD, 16'hF66F, 16'hF3BF,
    16'hDEED, 16'hCCCF, 16'hFB99, 16'hDDBB, 16'h7DDF,
    16'hFDFC, 16'h6AAF, 16'hFDED, 16'hFC3F, 16'hF666,
    16'hDDD7, 16'h99B6, 16'h99BF, 16'hDE7B, 16'hDF66,
    16'hF3CF, 16'h7DDF, 16'hE66F, 16'hF3EF, 16'hF13F,
    16'hDDF1, 16'hFC7F, 16'h8F9F, 16'hF366, 16'h7DBE,
    16'hF9F1, 16'h0002, 16'h2200, 16'h5500, 16'hF302,
    16'h6606, 16'hC88C, 16'h3113, 16'h04E4, 16'h00E0,
    16'h2020, 16'h8226, 16'h0000
  };

  // codes outside the table draw as the first glyph
  function automatic logic [15:0] font_bits(logic [7:0] code);
    logic [15:0] bits;
    bits = FONT_BITS[0];
    for (int i = 0; i < 48; i++) begin
      if (FONT_CODES[i] == code) bits = FONT_BITS[i];
    end
    return bits;
  endfunction

  class glyph_painter;
    logic [4:0]  scale;
    logic [15:0] ink;
    logic [15:0] paper;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    int          gap_columns;
    rect_word_t  due_rects[$];
    int          mismatches;
    int          rects_seen;
    int          blanks;

    function new(int gap);
      gap_columns = gap;
      scale       = PIXEL_SCALE_RST;
      ink         = INK_COLOUR_RST;
      paper       = PAPER_COLOUR_RST;
      pen_x       = '0;
      pen_y       = '0;
      mismatches  = 0;
      rects_seen  = 0;
      blanks      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_PIXEL_SCALE:  scale = val[4:0];
        REG_INK_COLOUR:   ink   = val;
        REG_PAPER_COLOUR: paper = val;
        default: ;
      endcase
    endfunction

    function void draw_char(char_word_t w);
      logic [4:0]  side;
      logic [15:0] bits;
      rect_word_t  r;
      side = (scale == 5'd0) ? 5'd1 : (scale > 5'd16) ? 5'd16 : scale;
      if (w.start_of_string) begin
        pen_x = w.origin_x;
        pen_y = w.origin_y;
      end
      bits = font_bits(w.char_code);
      if (bits == 16'h0000) blanks++;
      else begin
        for (int k = 0; k < 16; k++) begin
          r.rect_x        = pen_x + 16'(side * (k % 4));
          r.rect_y        = pen_y + 16'(side * (k / 4));
          r.rect_side     = side;
          r.fill_colour   = bits[15 - k] ? ink : paper;
          r.last_of_glyph = (k == 15);
          due_rects.push_back(r);
        end
      end
      pen_x = pen_x + 16'((4 + gap_columns) * side);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_rect(rect_word_t got);
      rect_word_t want;
      rects_seen++;
      if (due_rects.size() == 0) begin
        $error("square word with nothing pending: x=%h y=%h side=%0d colour=%h last=%b",
               got.rect_x, got.rect_y, got.rect_side, got.fill_colour, got.last_of_glyph);
        mismatches++;
        return;
      end
      want = due_rects.pop_front();
      compare_field("rect_x", want.rect_x, got.rect_x);
      compare_field("rect_y", want.rect_y, got.rect_y);
      compare_field("rect_side", 16'(want.rect_side), 16'(got.rect_side));
      compare_field("fill_colour", want.fill_colour, got.fill_colour);
      compare_field("last_of_glyph", 16'(want.last_of_glyph), 16'(got.last_of_glyph));
    endfunction
  endclass

endpackage

module tb;
  import btr_pkg::*;
  import glyph_bench_pkg::*;

  localparam int GAP          = GAP_COLUMNS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int QUIET_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        chr_valid = 1'b0;
  logic        chr_ready;
  char_word_t  chr = '0;
  logic        rect_valid;
  logic        rect_ready = 1'b0;
  rect_word_t  rect;

  glyph_painter painter;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  int          chars_sent = 0;
  int          settings_used = 1;

  bitmap_text_to_rect_generator #(
    .GAP_COLUMNS(GAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .chr_valid(chr_valid),
    .chr_ready(chr_ready),
    .chr(chr),
    .rect_valid(rect_valid),
    .rect_ready(rect_ready),
    .rect(rect)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d squares still pending",
               cycles, painter.due_rects.size());
      $display("** bitmap_text_to_rect_generator: FAILED **");
      $finish;
    end
  end

  // output side: check each accepted square word, then pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      rect_ready <= 1'b0;
    end else begin
      if (rect_valid && rect_ready) painter.match_rect(rect);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rect_ready <= 1'b0;
      end else begin
        rect_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int pick_gap(int pct);
    int g;
    g = 0;
    while (g < 12 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  function automatic char_word_t make_char(logic [7:0] code, logic start,
                                           logic [15:0] ox, logic [15:0] oy);
    char_word_t w;
    w.char_code       = code;
    w.start_of_string = start;
    w.origin_x        = ox;
    w.origin_y        = oy;
    return w;
  endfunction

  // mostly known characters in strings, some unknown codes, some origins
  // close to the top of the coordinate range
  function automatic char_word_t random_char();
    char_word_t w;
    if ($urandom_range(99) < 75) w.char_code = FONT_CODES[$urandom_range(47)];
    else w.char_code = 8'($urandom_range(255));
    w.start_of_string = ($urandom_range(5) == 0);
    w.origin_x = 16'($urandom());
    w.origin_y = 16'($urandom());
    if ($urandom_range(3) == 0) w.origin_x = 16'hFFFF - 16'($urandom_range(80));
    if ($urandom_range(3) == 0) w.origin_y = 16'hFFFF - 16'($urandom_range(80));
    return w;
  endfunction

  task automatic send_char(char_word_t w);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      chr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chr       <= w;
    chr_valid <= 1'b1;
    do @(posedge clk); while (!chr_ready);
    painter.draw_char(w);
    chars_sent++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_char(random_char());
  endtask

  // drop valid and wait for every pending square word
  task automatic drain_rects();
    chr_valid <= 1'b0;
    do @(posedge clk); while (painter.due_rects.size() != 0);
  endtask

  // blank glyphs never enter the queue; after the last square, idle for QUIET_CYCLES so extra square words are caught
  task automatic settle();
    drain_rects();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    painter.set_reg(idx, val);
  endtask

  task automatic load_settings(logic [4:0] scale, logic [15:0] ink, logic [15:0] paper);
    write_reg(REG_PIXEL_SCALE, {11'($urandom()), scale});
    write_reg(REG_INK_COLOUR, ink);
    write_reg(REG_PAPER_COLOUR, paper);
    write_reg(REG_UNUSED, 16'($urandom()));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0] probe_codes [$];
    painter = new(GAP);
    probe_codes = '{"a", "z", "0", "9", ".", "'", "\"", "?", "!", "[", "]", "+",
                    "-", ":", ";", " ", 8'h00, 8'hFF, "A", 8'h7B, 8'h80, " "};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, no idling: extremes of the code field and the font
    send_char(make_char("h", 1'b1, 16'h0000, 16'h0000));
    foreach (probe_codes[i]) send_char(make_char(probe_codes[i], 1'b0, '1, '1));
    send_char(make_char("m", 1'b1, 16'hFFFE, 16'hFFFD));
    send_char(make_char("w", 1'b0, 16'h0000, 16'h0000));
    settle();

    // largest scale, inverted colours, wrap near the top of the range
    load_settings(5'd16, 16'h0000, 16'hFFFF);
    send_char(make_char("8", 1'b1, 16'hFFF0, 16'hFFF8));
    send_random(45);
    settle();

    // scale 0 acts as 1; sender idles often
    send_idle_pct = 66;
    load_settings(5'd0, 16'($urandom()), 16'($urandom()));
    send_random(45);
    settle();

    // scale 31 acts as 16; receiver stalls often, then a long hold-off
    send_idle_pct = 0;
    stall_pct     = 66;
    load_settings(5'd31, 16'hAAAA, 16'h5555);
    send_random(40);
    hold_request = 1'b1;
    send_random(14);
    settle();

    // scale 17 acts as 16; both sides idle now and then
    send_idle_pct = 24;
    stall_pct     = 24;
    load_settings(5'd17, 16'($urandom()), 16'($urandom()));
    send_random(40);
    settle();

    // random in-range scale; pause the sender until the output is empty
    load_settings(5'($urandom_range(1, 16)), 16'($urandom()), 16'($urandom()));
    send_random(25);
    drain_rects();
    send_random(25);
    settle();

    $display("sent %0d characters (%0d blank) under %0d register settings,",
             chars_sent, painter.blanks, settings_used);
    $display("checked %0d square words with %0d mismatches",
             painter.rects_seen, painter.mismatches);
    if (painter.mismatches == 0) begin
      $display("** bitmap_text_to_rect_generator: PASSED **");
    end else begin
      $display("** bitmap_text_to_rect_generator: FAILED **");
    end
    $finish;
  end

endmodule
